// File: hw/rtl/dtss_pkg.sv
// ----------------------------------------------------------------------------
// dtss_pkg
// Shared types and constants of the dual temperature display refresh block.
// ----------------------------------------------------------------------------
package dtss_pkg;

    localparam int DIGITS = 6;
    localparam int IDX_W  = 3;

    // glyph codes: 0-9 are decimal digits
    localparam logic [3:0] GLYPH_DASH = 4'd10;

    typedef logic [DIGITS-1:0][3:0] t_codes;

    // one refresh worth of glyph codes handed from front to queue
    typedef struct packed {
        logic   valid;
        t_codes codes;
    } t_push;

    // head of the queue as seen by the back end
    typedef struct packed {
        logic   valid;
        t_codes codes;
    } t_head;

    localparam logic [7:0] SELECT_BYTE [DIGITS] = '{
        8'hFD, 8'hFB, 8'hF7, 8'hEF, 8'hDF, 8'hBF
    };

    function automatic logic [7:0] glyph_segments(input logic [3:0] code);
        logic [7:0] seg;
        unique case (code)
            4'd0:    seg = 8'h5F;
            4'd1:    seg = 8'h41;
            4'd2:    seg = 8'h9D;
            4'd3:    seg = 8'hD5;
            4'd4:    seg = 8'hC3;
            4'd5:    seg = 8'hD6;
            4'd6:    seg = 8'hDE;
            4'd7:    seg = 8'h45;
            4'd8:    seg = 8'hDF;
            4'd9:    seg = 8'hD7;
            default: seg = 8'h80;
        endcase
        return seg;
    endfunction

endpackage

// File: hw/rtl/dtss_front.sv
// ----------------------------------------------------------------------------
// dtss_front
// Accepts refresh items, runs the setpoint countdown, picks the values to
// show and splits them into glyph codes over a four-stage pipeline.
// ----------------------------------------------------------------------------
module dtss_front
    import dtss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [10:0] i_adc_sum_first,
    input  logic [10:0] i_adc_sum_second,
    input  logic [7:0]  i_offset_first,
    input  logic [7:0]  i_offset_second,
    input  logic [9:0]  i_setpoint_first,
    input  logic [9:0]  i_setpoint_second,
    input  logic        i_editing,
    input  logic        i_edit_select,
    input  logic        i_show_setpoint,
    output t_push       o_push,
    input  logic        i_q_full
);

    logic [7:0] r_ticks;
    logic [7:0] r_cd;

    logic             r_s1_v, r_s2_v, r_s3_v, r_s4_v;
    logic [1:0][10:0] r_s1_val, r_s2_val;
    logic [1:0][4:0]  r_s2_q;
    logic [1:0][3:0]  r_s3_hund, r_s4_hund;
    logic [1:0][6:0]  r_s3_rem, r_s4_rem;
    logic [1:0][3:0]  r_s4_tens;
    logic [1:0]       r_s1_dash, r_s2_dash, r_s3_dash, r_s4_dash;

    logic rdy1, rdy2, rdy3, rdy4, accept;

    // adc*512/1023: half the reading, plus one when the remainder reaches 1023
    function automatic logic [10:0] scale(input logic [10:0] raw, input logic [7:0] off);
        logic [9:0]  m;
        logic [10:0] rest;
        logic [10:0] q;
        m    = raw[10:1];
        rest = {1'b0, m} + (raw[0] ? 11'd512 : 11'd0);
        q    = {1'b0, m} + ((rest >= 11'd1023) ? 11'd1 : 11'd0);
        return q + {4'd0, off[7:1]};
    endfunction

    assign rdy4       = !r_s4_v || !i_q_full;
    assign rdy3       = !r_s3_v || rdy4;
    assign rdy2       = !r_s2_v || rdy3;
    assign rdy1       = !r_s1_v || rdy2;
    assign o_in_stall = !rdy1;
    assign accept     = i_in_valid && rdy1;

    // countdown and value selection
    logic [7:0]       cd_eff;
    logic             use_sp;
    logic [1:0][10:0] n_s1_val;
    logic [1:0]       n_s1_dash;

    always_comb begin
        cd_eff = i_show_setpoint ? r_ticks : r_cd;
        use_sp = (cd_eff != 8'd0);
        if (i_editing) begin
            n_s1_val[0] = {4'd0, i_offset_first[7:1]};
            n_s1_val[1] = {4'd0, i_offset_second[7:1]};
        end else if (use_sp) begin
            n_s1_val[0] = {1'b0, i_setpoint_first};
            n_s1_val[1] = {1'b0, i_setpoint_second};
        end else begin
            n_s1_val[0] = scale(i_adc_sum_first, i_offset_first);
            n_s1_val[1] = scale(i_adc_sum_second, i_offset_second);
        end
        n_s1_dash[0] = i_editing && i_edit_select;
        n_s1_dash[1] = i_editing && !i_edit_select;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks <= 8'd10;
            r_cd    <= 8'd0;
        end else begin
            if (i_cfg_valid) begin
                r_ticks <= i_cfg_data;
            end
            if (accept) begin
                r_cd <= use_sp ? cd_eff - 8'd1 : 8'd0;
            end
        end
    end

    // digit split stages
    logic [1:0][4:0]  n_s2_q;
    logic [1:0][3:0]  n_s3_hund;
    logic [1:0][6:0]  n_s3_rem;
    logic [1:0][3:0]  n_s4_tens;
    logic [1:0][3:0]  units;

    always_comb begin
        logic [21:0] prod_q;
        logic [10:0] diff;
        logic [14:0] prod_t;
        logic [6:0]  diff_u;
        for (int c = 0; c < 2; c++) begin
            // floor(v/100) by reciprocal, exact below 2048
            prod_q    = 22'(r_s1_val[c]) * 22'd1311;
            n_s2_q[c] = prod_q[21:17];

            diff        = r_s2_val[c] - 11'(r_s2_q[c]) * 11'd100;
            n_s3_rem[c] = diff[6:0];
            if (r_s2_q[c] >= 5'd20) begin
                n_s3_hund[c] = 4'(r_s2_q[c] - 5'd20);
            end else if (r_s2_q[c] >= 5'd10) begin
                n_s3_hund[c] = 4'(r_s2_q[c] - 5'd10);
            end else begin
                n_s3_hund[c] = r_s2_q[c][3:0];
            end

            prod_t       = 15'(r_s3_rem[c]) * 15'd205;
            n_s4_tens[c] = prod_t[14:11];

            diff_u   = r_s4_rem[c] - 7'(r_s4_tens[c]) * 7'd10;
            units[c] = diff_u[3:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
        end else begin
            if (rdy1) r_s1_v <= i_in_valid;
            if (rdy2) r_s2_v <= r_s1_v;
            if (rdy3) r_s3_v <= r_s2_v;
            if (rdy4) r_s4_v <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_val  <= n_s1_val;
            r_s1_dash <= n_s1_dash;
        end
        if (rdy2) begin
            r_s2_val  <= r_s1_val;
            r_s2_q    <= n_s2_q;
            r_s2_dash <= r_s1_dash;
        end
        if (rdy3) begin
            r_s3_hund <= n_s3_hund;
            r_s3_rem  <= n_s3_rem;
            r_s3_dash <= r_s2_dash;
        end
        if (rdy4) begin
            r_s4_hund <= r_s3_hund;
            r_s4_rem  <= r_s3_rem;
            r_s4_tens <= n_s4_tens;
            r_s4_dash <= r_s3_dash;
        end
    end

    always_comb begin
        o_push.valid = r_s4_v && !i_q_full;
        for (int c = 0; c < 2; c++) begin
            // the dash replaces the hundreds digit of its field
            o_push.codes[3*c]     = r_s4_dash[c] ? GLYPH_DASH : r_s4_hund[c];
            o_push.codes[3*c + 1] = r_s4_tens[c];
            o_push.codes[3*c + 2] = units[c];
        end
    end

endmodule

// File: hw/rtl/dtss_queue.sv
// ----------------------------------------------------------------------------
// dtss_queue
// Two-entry queue of glyph code sets between the front and back ends.
// ----------------------------------------------------------------------------
module dtss_queue
    import dtss_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    output logic  o_full,
    output t_head o_head,
    input  logic  i_pop
);

    localparam int QDEPTH = 2;
    localparam int PTR_W  = $clog2(QDEPTH);

    t_codes             r_mem [QDEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [PTR_W:0]     r_count;

    assign o_full       = (r_count == (PTR_W+1)'(QDEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.codes = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            priority if (i_push.valid && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push.valid) begin
                r_count <= r_count - 1'b1;
            end else begin
                r_count <= r_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.codes;
        end
    end

endmodule

// File: hw/rtl/dtss_back.sv
// ----------------------------------------------------------------------------
// dtss_back
// Walks the queue head one digit per cycle, while the receiver does not stall, into the output register.
// ----------------------------------------------------------------------------
module dtss_back
    import dtss_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_head            i_head,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [IDX_W-1:0] o_digit_index,
    output logic [7:0]       o_digit_select,
    output logic [7:0]       o_segments,
    output logic             o_last
);

    logic             r_out_v;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_digit_index;
    logic [7:0]       r_select;
    logic [7:0]       r_segments;
    logic             r_last;
    logic             load, at_last;

    assign at_last = (r_idx == IDX_W'(DIGITS - 1));
    assign load    = i_head.valid && (!r_out_v || !i_out_stall);
    assign o_pop   = load && at_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_out_v <= 1'b1;
                r_idx   <= at_last ? '0 : r_idx + 1'b1;
            end else if (!i_out_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_digit_index <= r_idx;
            r_select      <= SELECT_BYTE[r_idx];
            r_segments    <= glyph_segments(i_head.codes[r_idx]);
            r_last        <= at_last;
        end
    end

    assign o_out_valid    = r_out_v;
    assign o_digit_index  = r_digit_index;
    assign o_digit_select = r_select;
    assign o_segments     = r_segments;
    assign o_last         = r_last;

endmodule

// File: hw/rtl/dual_temp_seven_segment_refresh.sv
// ----------------------------------------------------------------------------
// dual_temp_seven_segment_refresh
// Six-digit seven-segment refresh for a two-channel temperature display.
// ----------------------------------------------------------------------------
// Each input transfer is one refresh: two adc sums, two offsets, two
// setpoints and the edit / show flags. It yields six output transfers, one
// per digit left to right, each with an active-low select byte, a segment
// byte and a last flag on the sixth digit.
// Channels use valid/stall; a transfer happens when valid is high and stall
// is low. The show_ticks register is written through the cfg channel, which
// is always ready; write it only while the block is idle.
// The first digit of a refresh passes through the four split stages, the
// queue write and the output register before it is presented.
// The back end emits one digit per cycle while the receiver does not stall,
// so it sets the refresh rate; the front takes a new refresh every cycle
// while its pipeline and the two-entry queue have room.
// When the receiver stalls, the output register holds its digit, the queue
// and the front stages fill, and then the input stall rises.
// Reset clears the countdown, sets show_ticks to 10 and empties all stages.
// ----------------------------------------------------------------------------
module dual_temp_seven_segment_refresh
    import dtss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [10:0] i_adc_sum_first,
    input  logic [10:0] i_adc_sum_second,
    input  logic [7:0]  i_offset_first,
    input  logic [7:0]  i_offset_second,
    input  logic [9:0]  i_setpoint_first,
    input  logic [9:0]  i_setpoint_second,
    input  logic        i_editing,
    input  logic        i_edit_select,
    input  logic        i_show_setpoint,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_digit_index,
    output logic [7:0]  o_digit_select,
    output logic [7:0]  o_segments,
    output logic        o_last
);

    t_push push;
    t_head head;
    logic  q_full, pop;

    assign o_cfg_ready = 1'b1;

    dtss_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_adc_sum_first   (i_adc_sum_first),
        .i_adc_sum_second  (i_adc_sum_second),
        .i_offset_first    (i_offset_first),
        .i_offset_second   (i_offset_second),
        .i_setpoint_first  (i_setpoint_first),
        .i_setpoint_second (i_setpoint_second),
        .i_editing         (i_editing),
        .i_edit_select     (i_edit_select),
        .i_show_setpoint   (i_show_setpoint),
        .o_push            (push),
        .i_q_full          (q_full)
    );

    dtss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .o_head  (head),
        .i_pop   (pop)
    );

    dtss_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_digit_index  (o_digit_index),
        .o_digit_select (o_digit_select),
        .o_segments     (o_segments),
        .o_last         (o_last)
    );

endmodule

// File: hw/rtl/dtss_check.sv
// ----------------------------------------------------------------------------
// dtss_check
// Port-level checks of the refresh block, bound to the top level.
// ----------------------------------------------------------------------------
module dtss_check
    import dtss_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [2:0] o_digit_index,
    input logic [7:0] o_digit_select,
    input logic [7:0] o_segments,
    input logic       o_last
);

    // last flag marks exactly the final digit position
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last == (o_digit_index == 3'(DIGITS - 1))))
        else $error("last flag does not match digit position");

    // select byte has its zero bit one above the digit index
    a_select: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_digit_select == ~(8'd1 << (o_digit_index + 3'd1))))
        else $error("digit select byte does not match digit index");

    // digits of a refresh come in order
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_last) |=>
        (!o_out_valid || (o_digit_index == $past(o_digit_index) + 3'd1)))
        else $error("digit index skipped or repeated");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_segments)))
        else $error("stalled output transfer changed");

endmodule

bind dual_temp_seven_segment_refresh dtss_check u_check (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_digit_index  (o_digit_index),
    .o_digit_select (o_digit_select),
    .o_segments     (o_segments),
    .o_last         (o_last)
);
